// ===== design/bde_pkg.sv =====
// Shared types and constants for the BRIEF descriptor engine.
// No dependencies; used by brief_descriptor_engine.

package bde_pkg;

    localparam int MAX_PAIRS    = 256;
    localparam int MAX_SIDE     = 31;
    localparam int CHANNEL_BITS = 16;

    localparam int PATCH_DEPTH = 1024;
    localparam int POS_W       = 10;
    localparam int WORD_BITS   = 32;
    localparam int MAX_WORDS   = 8;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;

    // input function codes
    localparam logic [1:0] FUNC_PAIR    = 2'd0;
    localparam logic [1:0] FUNC_PIXEL   = 2'd1;
    localparam logic [1:0] FUNC_COMPUTE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PATCH_SIDE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAIR_COUNT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd3;

    localparam logic [4:0]  PATCH_SIDE_RST   = 5'd9;
    localparam logic [8:0]  PAIR_COUNT_RST   = 9'd256;
    localparam logic [12:0] IMAGE_WIDTH_RST  = 13'd640;
    localparam logic [12:0] IMAGE_HEIGHT_RST = 13'd480;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  pair_index;
        logic [9:0]  first_pos;
        logic [9:0]  second_pos;
        logic [9:0]  pixel_index;
        logic [15:0] chan_red;
        logic [15:0] chan_green;
        logic [15:0] chan_blue;
        logic [11:0] key_x;
        logic [11:0] key_y;
    } in_item_t;

    typedef struct packed {
        logic [31:0] desc_word;
        logic [2:0]  word_index;
        logic        last_word;
        logic        rejected;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RUN
    } state_t;

endpackage

// ===== design/bde_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.

module bde_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/brief_descriptor_engine.sv =====
// BRIEF binary descriptor engine: pair table, patch store and compare pipeline.
// Depends on bde_pkg and bde_ram.
//
// Load items (pair entry or patch pixel) are taken one per cycle and write
// straight into the pair table or the patch store. A compute item has its
// border check and word count registered and enters the check state; a
// rejected key point or an empty pair count then gives its single result.
// Otherwise the pair table is read one entry per cycle while the pipeline is
// not frozen, both pixels of a pair are read from two copies of the patch
// store at the registered pair entry, and the registered pixel sums are
// compared. The input is not ready while a compute item is in flight.
// Results wait in an output register; the compare pipeline freezes when a
// finished word finds that register still occupied.

module brief_descriptor_engine #(
    parameter int MAX_PAIRS    = bde_pkg::MAX_PAIRS,
    parameter int MAX_SIDE     = bde_pkg::MAX_SIDE,
    parameter int CHANNEL_BITS = bde_pkg::CHANNEL_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [bde_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bde_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  bde_pkg::in_item_t                  in_item,
    output logic                               out_valid,
    input  logic                               out_ready,
    output bde_pkg::out_item_t                 out_item
);

    localparam int PAIR_AW  = $clog2(MAX_PAIRS);
    localparam int SUM_W    = CHANNEL_BITS + 2;
    localparam int CH_USE   = (CHANNEL_BITS < 16) ? CHANNEL_BITS : 16;
    localparam int PATCH_AW = $clog2(bde_pkg::PATCH_DEPTH);
    localparam logic [15:0] CH_MASK     = 16'((32'd1 << CH_USE) - 32'd1);
    localparam logic [10:0] MAX_PAIRS_W = 11'(MAX_PAIRS);
    localparam logic [5:0]  MAX_SIDE_W  = 6'(MAX_SIDE);

    // configuration registers
    logic [4:0]  patch_side_reg;
    logic [8:0]  pair_count_reg;
    logic [12:0] image_width_reg;
    logic [12:0] image_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            patch_side_reg   <= bde_pkg::PATCH_SIDE_RST;
            pair_count_reg   <= bde_pkg::PAIR_COUNT_RST;
            image_width_reg  <= bde_pkg::IMAGE_WIDTH_RST;
            image_height_reg <= bde_pkg::IMAGE_HEIGHT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                bde_pkg::CFG_PATCH_SIDE:   patch_side_reg   <= cfg_wdata[4:0];
                bde_pkg::CFG_PAIR_COUNT:   pair_count_reg   <= cfg_wdata[8:0];
                bde_pkg::CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata;
                bde_pkg::CFG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    bde_pkg::state_t state_reg, state_next;

    logic        in_xfer;
    logic        out_free;
    logic        adv;
    logic        issue_en;
    logic        single_load;
    logic        word_load;
    logic        word_done_last;
    logic        pair_re;
    logic        patch_re;

    logic        rej_reg, rej_next;
    logic [3:0]  words_reg, words_next;
    logic [8:0]  issue_cnt_reg, issue_cnt_next;
    logic [8:0]  total_pairs;
    logic        s1_valid_reg, s1_valid_next;
    logic        s2_valid_reg, s2_valid_next;
    logic [7:0]  s1_idx_reg, s1_idx_next;
    logic [7:0]  s2_idx_reg, s2_idx_next;
    logic [30:0] acc_reg, acc_next;
    logic        out_valid_reg, out_valid_next;
    bde_pkg::out_item_t out_data_reg, out_data_next;

    // border check and word count, evaluated on the compute transfer
    logic [5:0]  side_lim;
    logic [4:0]  half_side;
    logic        key_ok;
    logic [10:0] pairs_lim;
    logic [5:0]  words_raw;
    logic [3:0]  words_calc;

    always_comb
    begin
        side_lim  = ({1'b0, patch_side_reg} > MAX_SIDE_W) ? MAX_SIDE_W
                                                          : {1'b0, patch_side_reg};
        half_side = side_lim[5:1];
        key_ok = (in_item.key_x >= 12'(half_side))
              && ((13'(in_item.key_x) + 13'(half_side)) < image_width_reg)
              && (in_item.key_y >= 12'(half_side))
              && ((13'(in_item.key_y) + 13'(half_side)) < image_height_reg);
        pairs_lim  = (11'(pair_count_reg) > MAX_PAIRS_W) ? MAX_PAIRS_W
                                                         : 11'(pair_count_reg);
        words_raw  = pairs_lim[10:5];
        words_calc = (words_raw > 6'(bde_pkg::MAX_WORDS)) ? 4'(bde_pkg::MAX_WORDS)
                                                          : words_raw[3:0];
    end

    // memories
    logic [2*bde_pkg::POS_W-1:0] pair_rdata;
    logic [SUM_W-1:0]            pix_a_rdata;
    logic [SUM_W-1:0]            pix_b_rdata;
    logic [SUM_W-1:0]            pix_sum;
    logic                        pair_we;
    logic                        pix_we;

    assign in_xfer = in_valid && in_ready;
    assign pair_we = in_xfer && (in_item.func == bde_pkg::FUNC_PAIR)
                  && (11'(in_item.pair_index) < MAX_PAIRS_W);
    assign pix_we  = in_xfer && (in_item.func == bde_pkg::FUNC_PIXEL);
    assign pix_sum = SUM_W'(in_item.chan_red & CH_MASK)
                   + SUM_W'(in_item.chan_green & CH_MASK)
                   + SUM_W'(in_item.chan_blue & CH_MASK);

    bde_ram #(
        .WIDTH (2 * bde_pkg::POS_W),
        .DEPTH (MAX_PAIRS)
    ) u_pair_ram (
        .clk   (clk),
        .we    (pair_we),
        .waddr (PAIR_AW'(in_item.pair_index)),
        .wdata ({in_item.second_pos, in_item.first_pos}),
        .re    (pair_re),
        .raddr (PAIR_AW'(issue_cnt_reg[7:0])),
        .rdata (pair_rdata)
    );

    // two copies of the patch store so both pixels of a pair read together
    bde_ram #(
        .WIDTH (SUM_W),
        .DEPTH (bde_pkg::PATCH_DEPTH)
    ) u_patch_ram_a (
        .clk   (clk),
        .we    (pix_we),
        .waddr (PATCH_AW'(in_item.pixel_index)),
        .wdata (pix_sum),
        .re    (patch_re),
        .raddr (PATCH_AW'(pair_rdata[bde_pkg::POS_W-1:0])),
        .rdata (pix_a_rdata)
    );

    bde_ram #(
        .WIDTH (SUM_W),
        .DEPTH (bde_pkg::PATCH_DEPTH)
    ) u_patch_ram_b (
        .clk   (clk),
        .we    (pix_we),
        .waddr (PATCH_AW'(in_item.pixel_index)),
        .wdata (pix_sum),
        .re    (patch_re),
        .raddr (PATCH_AW'(pair_rdata[2*bde_pkg::POS_W-1:bde_pkg::POS_W])),
        .rdata (pix_b_rdata)
    );

    // control
    assign total_pairs = {words_reg, 5'd0};
    assign out_free    = !out_valid_reg || out_ready;
    assign adv         = !(s2_valid_reg && (s2_idx_reg[4:0] == 5'd31) && !out_free);
    assign word_load   = adv && s2_valid_reg && (s2_idx_reg[4:0] == 5'd31);
    assign word_done_last = word_load && ({1'b0, s2_idx_reg[7:5]} == (words_reg - 4'd1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bde_pkg::ST_IDLE:
            begin
                if (in_xfer && (in_item.func == bde_pkg::FUNC_COMPUTE))
                begin
                    state_next = bde_pkg::ST_CHECK;
                end
            end
            bde_pkg::ST_CHECK:
            begin
                if (rej_reg || (words_reg == 4'd0))
                begin
                    if (out_free)
                    begin
                        state_next = bde_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    state_next = bde_pkg::ST_RUN;
                end
            end
            bde_pkg::ST_RUN:
            begin
                if (word_done_last)
                begin
                    state_next = bde_pkg::ST_IDLE;
                end
            end
            default: state_next = bde_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        issue_en    = 1'b0;
        single_load = 1'b0;
        case (state_reg)
            bde_pkg::ST_IDLE:  in_ready = 1'b1;
            bde_pkg::ST_CHECK: single_load = (rej_reg || (words_reg == 4'd0)) && out_free;
            bde_pkg::ST_RUN:   issue_en = adv && (issue_cnt_reg < total_pairs);
            default: ;
        endcase
        pair_re  = issue_en;
        patch_re = adv && s1_valid_reg;
    end

    always_comb
    begin
        rej_next       = rej_reg;
        words_next     = words_reg;
        issue_cnt_next = issue_cnt_reg;
        s1_valid_next  = s1_valid_reg;
        s2_valid_next  = s2_valid_reg;
        s1_idx_next    = s1_idx_reg;
        s2_idx_next    = s2_idx_reg;
        acc_next       = acc_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;

        if (in_xfer && (in_item.func == bde_pkg::FUNC_COMPUTE))
        begin
            rej_next       = !key_ok;
            words_next     = words_calc;
            issue_cnt_next = 9'd0;
        end

        if (adv)
        begin
            s1_valid_next = issue_en;
            s1_idx_next   = issue_cnt_reg[7:0];
            s2_valid_next = s1_valid_reg;
            s2_idx_next   = s1_idx_reg;
        end
        if (issue_en)
        begin
            issue_cnt_next = issue_cnt_reg + 9'd1;
        end

        if (adv && s2_valid_reg && (s2_idx_reg[4:0] != 5'd31))
        begin
            acc_next[s2_idx_reg[4:0]] = pix_a_rdata > pix_b_rdata;
        end

        if (word_load)
        begin
            out_valid_next           = 1'b1;
            out_data_next.desc_word  = {pix_a_rdata > pix_b_rdata, acc_reg};
            out_data_next.word_index = s2_idx_reg[7:5];
            out_data_next.last_word  = word_done_last;
            out_data_next.rejected   = 1'b0;
        end
        else if (single_load)
        begin
            out_valid_next           = 1'b1;
            out_data_next.desc_word  = 32'd0;
            out_data_next.word_index = 3'd0;
            out_data_next.last_word  = 1'b1;
            out_data_next.rejected   = rej_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bde_pkg::ST_IDLE;
            issue_cnt_reg <= 9'd0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rej_reg       <= 1'b0;
            words_reg     <= 4'd0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            rej_reg       <= rej_next;
            words_reg     <= words_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg   <= s1_idx_next;
        s2_idx_reg   <= s2_idx_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_data_reg;

`ifndef ASSERT_OFF
    // no new item may enter while pairs are still in the compare pipeline
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg || s2_valid_reg) |-> !in_ready)
        else $error("input ready while compare pipeline busy");

    // a finished word only lands in a free output register
    a_word_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        word_load |-> (!out_valid_reg || out_ready))
        else $error("descriptor word overwrote a pending result");

    // issue never runs past the configured pair total
    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bde_pkg::ST_RUN) |-> (issue_cnt_reg <= total_pairs))
        else $error("pair issue counter beyond pair total");

    // a rejected result is always the only, and so last, word
    a_reject_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.rejected) |->
            (out_data_reg.last_word && (out_data_reg.word_index == 3'd0)))
        else $error("rejected result not a single last word");

    // a frozen pipeline keeps its stage-2 pair
    a_freeze_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !adv) |=> (s2_valid_reg && $stable(s2_idx_reg)))
        else $error("stage 2 moved while frozen");
`endif

endmodule

// ===== dv/brief_descriptor_engine_tb.sv =====
// Testbench for brief_descriptor_engine: loads pair tables and patch pixels,
// requests descriptors under several register settings and checks every word.
// Depends on bde_pkg and the brief_descriptor_engine RTL.
`timescale 1ns / 100ps

module brief_descriptor_engine_tb;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam int PHASE_ITEMS   = 25;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 300;
    localparam int HOLD_CYCLES   = 300;
    localparam int TIMEOUT_NS    = 10_000_000;

    // Mirrors the engine: pair table, channel sums, registers, words still owed.
    class descriptor_book;
        logic [2*bde_pkg::POS_W-1:0]      pair_table [bde_pkg::MAX_PAIRS];
        logic [bde_pkg::CHANNEL_BITS+1:0] patch_sums [bde_pkg::PATCH_DEPTH];
        logic [4:0]                       cfg_side;
        logic [8:0]                       cfg_pairs;
        logic [12:0]                      cfg_width;
        logic [12:0]                      cfg_height;
        bde_pkg::out_item_t               pending_words [$];
        int failures;
        int loads;
        int requests;
        int rejects;
        int words_checked;

        function new();
            cfg_side   = bde_pkg::PATCH_SIDE_RST;
            cfg_pairs  = bde_pkg::PAIR_COUNT_RST;
            cfg_width  = bde_pkg::IMAGE_WIDTH_RST;
            cfg_height = bde_pkg::IMAGE_HEIGHT_RST;
        endfunction

        function void set_reg(logic [bde_pkg::CFG_INDEX_W-1:0] idx,
                              logic [bde_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                bde_pkg::CFG_PATCH_SIDE:   cfg_side   = data[4:0];
                bde_pkg::CFG_PAIR_COUNT:   cfg_pairs  = data[8:0];
                bde_pkg::CFG_IMAGE_WIDTH:  cfg_width  = data[12:0];
                bde_pkg::CFG_IMAGE_HEIGHT: cfg_height = data[12:0];
                default: ;
            endcase
        endfunction

        function void push_word(logic [bde_pkg::WORD_BITS-1:0] bits, int w, bit last, bit rej);
            bde_pkg::out_item_t r;
            r.desc_word  = bits;
            r.word_index = 3'(w);
            r.last_word  = last;
            r.rejected   = rej;
            pending_words.push_back(r);
        endfunction

        function void predict_descriptor(logic [11:0] key_x, logic [11:0] key_y);
            int side;
            int half;
            int x;
            int y;
            int npairs;
            int words;
            logic [bde_pkg::WORD_BITS-1:0] bits;
            logic [2*bde_pkg::POS_W-1:0]   entry;
            requests++;
            side = (cfg_side > bde_pkg::MAX_SIDE) ? bde_pkg::MAX_SIDE : int'(cfg_side);
            half = side / 2;
            x = int'(key_x);
            y = int'(key_y);
            if (!(x >= half && x + half < int'(cfg_width) &&
                  y >= half && y + half < int'(cfg_height)))
            begin
                rejects++;
                push_word('0, 0, 1'b1, 1'b1);
                return;
            end
            npairs = (cfg_pairs > bde_pkg::MAX_PAIRS) ? bde_pkg::MAX_PAIRS : int'(cfg_pairs);
            words = npairs / bde_pkg::WORD_BITS;
            if (words > bde_pkg::MAX_WORDS)
                words = bde_pkg::MAX_WORDS;
            if (words == 0)
            begin
                push_word('0, 0, 1'b1, 1'b0);
                return;
            end
            for (int w = 0; w < words; w++)
            begin
                bits = '0;
                for (int b = 0; b < bde_pkg::WORD_BITS; b++)
                begin
                    entry = pair_table[(w * bde_pkg::WORD_BITS + b) % bde_pkg::MAX_PAIRS];
                    // strictly brighter; equal sums leave the bit clear
                    if (patch_sums[entry[bde_pkg::POS_W-1:0]]
                        > patch_sums[entry[2*bde_pkg::POS_W-1:bde_pkg::POS_W]])
                        bits[b] = 1'b1;
                end
                push_word(bits, w, w == words - 1, 1'b0);
            end
        endfunction

        function void note_item(bde_pkg::in_item_t it);
            case (it.func)
                bde_pkg::FUNC_PAIR:
                begin
                    pair_table[it.pair_index] = {it.second_pos, it.first_pos};
                    loads++;
                end
                bde_pkg::FUNC_PIXEL:
                begin
                    patch_sums[it.pixel_index] = {2'b00, it.chan_red} + {2'b00, it.chan_green}
                                               + {2'b00, it.chan_blue};
                    loads++;
                end
                bde_pkg::FUNC_COMPUTE: predict_descriptor(it.key_x, it.key_y);
                default: ;
            endcase
        endfunction

        function void check_word(bde_pkg::out_item_t got);
            bde_pkg::out_item_t want;
            if (pending_words.size() == 0)
            begin
                $error("descriptor word %h (index %0d) arrived with nothing expected",
                       got.desc_word, got.word_index);
                failures++;
                return;
            end
            want = pending_words.pop_front();
            words_checked++;
            if (got.desc_word !== want.desc_word)
            begin
                $error("desc_word: expected %h, got %h", want.desc_word, got.desc_word);
                failures++;
            end
            if (got.word_index !== want.word_index)
            begin
                $error("word_index: expected %0d, got %0d", want.word_index, got.word_index);
                failures++;
            end
            if (got.last_word !== want.last_word)
            begin
                $error("last_word: expected %b, got %b", want.last_word, got.last_word);
                failures++;
            end
            if (got.rejected !== want.rejected)
            begin
                $error("rejected: expected %b, got %b", want.rejected, got.rejected);
                failures++;
            end
        endfunction
    endclass

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [bde_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [bde_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    bde_pkg::in_item_t               in_item   = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    bde_pkg::out_item_t              out_item;

    descriptor_book book = new();

    bit pair_loaded  [bde_pkg::MAX_PAIRS];
    bit pixel_loaded [bde_pkg::PATCH_DEPTH];
    int pixel_pool [$];
    int items_sent;
    int settings_run;
    bit steady;
    bit hold_req;

    brief_descriptor_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offers one item and returns at the edge where its transfer happens.
    // valid stays high on return so back-to-back items need no drop.
    task automatic send_item(input bde_pkg::in_item_t it);
        while (!steady && $urandom_range(99) < 37)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        book.note_item(it);
    endtask

    function automatic bde_pkg::in_item_t random_item(logic [1:0] func);
        bde_pkg::in_item_t it;
        it.func        = func;
        it.pair_index  = 8'($urandom);
        it.first_pos   = 10'($urandom);
        it.second_pos  = 10'($urandom);
        it.pixel_index = 10'($urandom);
        it.chan_red    = 16'($urandom);
        it.chan_green  = 16'($urandom);
        it.chan_blue   = 16'($urandom);
        it.key_x       = 12'($urandom);
        it.key_y       = 12'($urandom);
        return it;
    endfunction

    function automatic logic [15:0] random_channel();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int pooled_pos();
        return pixel_pool[$urandom_range(pixel_pool.size() - 1)];
    endfunction

    task automatic load_pixel(int pos, logic [15:0] red, logic [15:0] green,
                              logic [15:0] blue);
        bde_pkg::in_item_t it;
        it = random_item(bde_pkg::FUNC_PIXEL);
        it.pixel_index = 10'(pos);
        it.chan_red    = red;
        it.chan_green  = green;
        it.chan_blue   = blue;
        send_item(it);
        if (!pixel_loaded[pos])
        begin
            pixel_loaded[pos] = 1'b1;
            pixel_pool.push_back(pos);
        end
        items_sent++;
    endtask

    task automatic load_pair(int idx, int first, int second);
        bde_pkg::in_item_t it;
        it = random_item(bde_pkg::FUNC_PAIR);
        it.pair_index = 8'(idx);
        it.first_pos  = 10'(first);
        it.second_pos = 10'(second);
        send_item(it);
        pair_loaded[idx] = 1'b1;
        items_sent++;
    endtask

    task automatic request_descriptor(int key_x, int key_y);
        bde_pkg::in_item_t it;
        it = random_item(bde_pkg::FUNC_COMPUTE);
        it.key_x = 12'(key_x);
        it.key_y = 12'(key_y);
        send_item(it);
        items_sent++;
    endtask

    task automatic send_noise();
        send_item(random_item(FUNC_UNUSED));
    endtask

    // Key coordinate along one axis, biased to the accept/reject boundaries.
    function automatic int pick_axis(int extent, int half);
        int hi;
        if (extent <= 2 * half)
            return $urandom_range(4095);
        hi = extent - 1 - half;
        if (hi > 4095)
            hi = 4095;
        case ($urandom_range(9))
            0: return half;
            1: return hi;
            2: return (half > 0) ? half - 1 : 4095;
            3: return (extent - half > 4095) ? 4095 : extent - half;
            4: return $urandom_range(4095);
            default: return $urandom_range(hi, half);
        endcase
    endfunction

    task automatic request_random();
        int half;
        half = int'(book.cfg_side) / 2;
        request_descriptor(pick_axis(int'(book.cfg_width), half),
                           pick_axis(int'(book.cfg_height), half));
    endtask

    // Every pair a request can touch must hold a written entry first.
    task automatic fill_pairs();
        int need;
        need = (book.cfg_pairs > bde_pkg::MAX_PAIRS) ? bde_pkg::MAX_PAIRS
                                                     : int'(book.cfg_pairs);
        for (int i = 0; i < need; i++)
        begin
            if (!pair_loaded[i])
                load_pair(i, pooled_pos(), pooled_pos());
        end
    endtask

    task automatic patch_sequence();
        int side_sq;
        int pos;
        int first;
        side_sq = int'(book.cfg_side) * int'(book.cfg_side);
        if ($urandom_range(7) == 0)
            send_noise();
        repeat ($urandom_range(4, 1))
        begin
            pos = ($urandom_range(4) == 0 || side_sq == 0)
                ? $urandom_range(bde_pkg::PATCH_DEPTH - 1)
                : $urandom_range(side_sq - 1);
            load_pixel(pos, random_channel(), random_channel(), random_channel());
        end
        // abandoned sequence: pixels only
        if ($urandom_range(5) == 0)
            return;
        repeat ($urandom_range(3))
        begin
            first = pooled_pos();
            load_pair($urandom_range(bde_pkg::MAX_PAIRS - 1), first,
                      ($urandom_range(9) == 0) ? first : pooled_pos());
        end
        fill_pairs();
        repeat ($urandom_range(3, 1))
            request_random();
    endtask

    // Wait for all owed words, then let the load path drain before a register write.
    task automatic settle();
        in_valid <= 1'b0;
        while (book.pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [bde_pkg::CFG_INDEX_W-1:0] idx, int value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= bde_pkg::CFG_DATA_W'(value);
        @(posedge clk);
        book.set_reg(idx, bde_pkg::CFG_DATA_W'(value));
    endtask

    task automatic run_phase(int side, int pairs, int width, int height, bit squeeze);
        int start;
        settle();
        write_reg(bde_pkg::CFG_PATCH_SIDE, side);
        write_reg(bde_pkg::CFG_PAIR_COUNT, pairs);
        write_reg(bde_pkg::CFG_IMAGE_WIDTH, width);
        write_reg(bde_pkg::CFG_IMAGE_HEIGHT, height);
        cfg_wr_en <= 1'b0;
        settings_run++;
        start = items_sent;
        if (squeeze)
        begin
            // receiver stalls while requests keep coming: the engine backs up
            fill_pairs();
            hold_req = 1'b1;
            repeat (6) request_random();
        end
        while (items_sent - start < PHASE_ITEMS)
            patch_sequence();
    endtask

    // Result side: random ready, plus one long hold-off on request.
    initial
    begin
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            out_ready <= steady || ($urandom_range(99) >= 37);
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                book.check_word(out_item);
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("brief_descriptor_engine test failed");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: side 9, 640x480, so only border rejections are safe here
        load_pixel(0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        load_pixel(bde_pkg::PATCH_DEPTH - 1, 16'h0000, 16'h0000, 16'h0000);
        load_pixel(40, 16'h1234, 16'h0000, 16'h0000);
        load_pixel(41, 16'h0000, 16'h1234, 16'h0000);
        load_pair(bde_pkg::MAX_PAIRS - 1, bde_pkg::PATCH_DEPTH - 1, 0);
        load_pair(0, 0, bde_pkg::PATCH_DEPTH - 1);
        load_pair(1, 40, 41);
        send_noise();
        request_descriptor(3, 100);
        request_descriptor(100, 3);
        request_descriptor(636, 100);
        request_descriptor(100, 476);
        request_descriptor(4095, 4095);
        request_descriptor(0, 0);

        run_phase(3, 32, 16, 12, 1'b0);
        steady = 1'b1;
        run_phase(31, 64, 4096, 4096, 1'b0);
        steady = 1'b0;
        run_phase(0, 0, 1, 1, 1'b0);
        run_phase(9, 256, 640, 480, 1'b0);
        run_phase(8, 100, 8191, 8191, 1'b1);
        run_phase(1, 511, 0, 480, 1'b0);
        run_phase(17, 33, 100, 4096, 1'b0);
        run_phase(5, 31, 50, 50, 1'b0);
        run_phase(31, 256, 31, 31, 1'b0);
        run_phase(2, 160, 4096, 3, 1'b0);

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d loads and %0d descriptor requests (%0d at a border), %0d words",
                 book.loads, book.requests, book.rejects, book.words_checked);
        $display("checked across %0d register settings, including one long output stall.",
                 settings_run);
        if (book.failures == 0 && book.pending_words.size() == 0)
            $display("brief_descriptor_engine test passed");
        else
            $display("brief_descriptor_engine test failed");
        $finish;
    end

endmodule
